>>> rtl/cbm_pkg.sv
package cbm_pkg;

    localparam int MEM_ADDR_BITS_DEF = 21;
    localparam int ADDR_FULL_BITS    = 24;

    localparam int BANK_BITS      = 8;
    localparam int COUNT_BITS     = 9;
    localparam int BITS_PER_STEP  = 2;
    localparam int DIV_STEPS      = BANK_BITS / BITS_PER_STEP;
    localparam int STEP_BITS      = $clog2(DIV_STEPS);

    localparam logic [2:0] CMD_CPU_WRITE = 3'd0;
    localparam logic [2:0] CMD_CPU_READ  = 3'd1;
    localparam logic [2:0] CMD_PPU_READ  = 3'd2;
    localparam logic [2:0] CMD_PPU_WRITE = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;

    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM = 3'd3;
    localparam logic [2:0] TGT_CHR_RAM = 3'd4;

    localparam logic [3:0] MC_PRG_LOW  = 4'h8;
    localparam logic [3:0] MC_PRG_0    = 4'h9;
    localparam logic [3:0] MC_PRG_1    = 4'hA;
    localparam logic [3:0] MC_PRG_2    = 4'hB;
    localparam logic [3:0] MC_MIRROR   = 4'hC;
    localparam logic [3:0] MC_IRQ_CTRL = 4'hD;
    localparam logic [3:0] MC_CNT_LO   = 4'hE;
    localparam logic [3:0] MC_CNT_HI   = 4'hF;

    localparam logic [2:0] WIN_LOW     = 3'b011;
    localparam logic [2:0] WIN_LATCH   = 3'b100;
    localparam logic [2:0] WIN_EXEC    = 3'b101;
    localparam logic [2:0] WIN_FIXED   = 3'b111;

    localparam logic [1:0] REG_PRG_COUNT = 2'd0;
    localparam logic [1:0] REG_CHR_COUNT = 2'd1;
    localparam logic [1:0] REG_CHR_RAM   = 2'd2;
    localparam logic [1:0] REG_MIRROR    = 2'd3;

    localparam logic [COUNT_BITS-1:0] PRG_COUNT_RST = 9'd32;
    localparam logic [COUNT_BITS-1:0] CHR_COUNT_RST = 9'd256;

    typedef struct packed {
        logic load;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic needs_div;
    } t_dp_status;

endpackage

>>> rtl/cbm_ctrl.sv
module cbm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  cbm_pkg::t_dp_status i_status,
    output cbm_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    localparam logic [cbm_pkg::STEP_BITS-1:0] LAST_STEP =
        cbm_pkg::STEP_BITS'(cbm_pkg::DIV_STEPS - 1);

    logic [1:0]                   r_state, n_state;
    logic [cbm_pkg::STEP_BITS-1:0] r_step, n_step;
    logic                         r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = i_status.needs_div ? S_DIV : S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/cbm_datapath.sv
module cbm_datapath #(
    parameter int MEM_ADDR_BITS = cbm_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cbm_pkg::t_ctrl_cmd        i_cmd,
    output cbm_pkg::t_dp_status       o_status,
    input  logic [2:0]                i_command,
    input  logic [15:0]               i_address,
    input  logic [7:0]                i_data_in,
    input  logic                      i_cfg_valid,
    input  logic [1:0]                i_cfg_index,
    input  logic [8:0]                i_cfg_data,
    output logic [2:0]                o_target,
    output logic [MEM_ADDR_BITS-1:0]  o_mem_addr,
    output logic                      o_mem_write,
    output logic [7:0]                o_write_data,
    output logic                      o_irq,
    output logic [1:0]                o_mirroring
);

    localparam int BB = cbm_pkg::BANK_BITS;
    localparam int CB = cbm_pkg::COUNT_BITS;

    function automatic logic [CB-1:0] rem_step(input logic [CB-1:0] rem,
                                               input logic          b,
                                               input logic [CB-1:0] dsr);
        logic [CB:0] t;
        logic [CB:0] d;
        t = {rem, b};
        d = {1'b0, dsr};
        if (t >= d) begin
            rem_step = CB'(t - d);
        end else begin
            rem_step = t[CB-1:0];
        end
    endfunction

    logic [CB-1:0] r_prg_count, n_prg_count;
    logic [CB-1:0] r_chr_count, n_chr_count;
    logic          r_chr_ram, n_chr_ram;
    logic [1:0]    r_init_mirror, n_init_mirror;

    logic [3:0]    r_latch, n_latch;
    logic [7:0]    r_chr_bank [8];
    logic [7:0]    n_chr_bank [8];
    logic [5:0]    r_prg_bank [4];
    logic [5:0]    n_prg_bank [4];
    logic          r_low_ram, n_low_ram;
    logic [1:0]    r_mirror, n_mirror;
    logic          r_cnt_en, n_cnt_en;
    logic          r_irq_en, n_irq_en;
    logic          r_irq_pend, n_irq_pend;
    logic [15:0]   r_counter, n_counter;

    logic [2:0]    r_target;
    logic          r_wr;
    logic [7:0]    r_wdata;
    logic [12:0]   r_off;
    logic [CB-1:0] r_rem;
    logic [BB-1:0] r_dvd;
    logic [CB-1:0] r_dsr;

    logic [2:0]    dec_target;
    logic          dec_wr;
    logic          dec_div;
    logic [BB-1:0] dec_dvd;
    logic [CB-1:0] dec_dsr;
    logic [CB-1:0] dec_bank;
    logic [2:0]    win;
    logic [12:0]   off;

    logic [CB-1:0] rem_mid;
    logic [CB-1:0] rem_end;
    logic [cbm_pkg::ADDR_FULL_BITS-1:0] full_addr;

    assign win = i_address[15:13];
    assign off = i_address[12:0];

    always_comb begin
        n_prg_count   = r_prg_count;
        n_chr_count   = r_chr_count;
        n_chr_ram     = r_chr_ram;
        n_init_mirror = r_init_mirror;
        n_latch       = r_latch;
        n_chr_bank    = r_chr_bank;
        n_prg_bank    = r_prg_bank;
        n_low_ram     = r_low_ram;
        n_mirror      = r_mirror;
        n_cnt_en      = r_cnt_en;
        n_irq_en      = r_irq_en;
        n_irq_pend    = r_irq_pend;
        n_counter     = r_counter;

        dec_target = cbm_pkg::TGT_NONE;
        dec_wr     = 1'b0;
        dec_div    = 1'b0;
        dec_dvd    = '0;
        dec_dsr    = r_prg_count;
        dec_bank   = '0;

        case (i_command)
            cbm_pkg::CMD_CPU_WRITE: begin
                if (win == cbm_pkg::WIN_LOW && r_low_ram) begin
                    dec_target = cbm_pkg::TGT_PRG_RAM;
                    dec_wr     = 1'b1;
                end
            end
            cbm_pkg::CMD_CPU_READ: begin
                if (win == cbm_pkg::WIN_LOW && r_low_ram) begin
                    dec_target = cbm_pkg::TGT_PRG_RAM;
                end else if (win >= cbm_pkg::WIN_LOW && r_prg_count != '0) begin
                    dec_target = cbm_pkg::TGT_PRG_ROM;
                    if (win == cbm_pkg::WIN_FIXED) begin
                        dec_bank = r_prg_count - 1'b1;
                    end else if (win == cbm_pkg::WIN_LOW) begin
                        dec_div = 1'b1;
                        dec_dvd = BB'(r_prg_bank[3]);
                    end else begin
                        dec_div = 1'b1;
                        dec_dvd = BB'(r_prg_bank[i_address[14:13]]);
                    end
                end
            end
            cbm_pkg::CMD_PPU_READ, cbm_pkg::CMD_PPU_WRITE: begin
                if (r_chr_ram) begin
                    dec_target = cbm_pkg::TGT_CHR_RAM;
                    dec_wr     = (i_command == cbm_pkg::CMD_PPU_WRITE);
                end else if (i_command == cbm_pkg::CMD_PPU_READ && r_chr_count != '0) begin
                    dec_target = cbm_pkg::TGT_CHR_ROM;
                    dec_div    = 1'b1;
                    dec_dvd    = r_chr_bank[off[12:10]];
                    dec_dsr    = r_chr_count;
                end
            end
            default: begin
            end
        endcase

        if (i_cmd.load) begin
            if (i_command == cbm_pkg::CMD_CPU_WRITE && win == cbm_pkg::WIN_LATCH) begin
                n_latch = i_data_in[3:0];
            end
            if (i_command == cbm_pkg::CMD_CPU_WRITE && win == cbm_pkg::WIN_EXEC) begin
                case (r_latch)
                    cbm_pkg::MC_PRG_LOW: begin
                        n_low_ram     = i_data_in[6];
                        n_prg_bank[3] = i_data_in[5:0];
                    end
                    cbm_pkg::MC_PRG_0: n_prg_bank[0] = i_data_in[5:0];
                    cbm_pkg::MC_PRG_1: n_prg_bank[1] = i_data_in[5:0];
                    cbm_pkg::MC_PRG_2: n_prg_bank[2] = i_data_in[5:0];
                    cbm_pkg::MC_MIRROR: begin
                        n_mirror = {i_data_in[1], i_data_in[1] ? i_data_in[0] : ~i_data_in[0]};
                    end
                    cbm_pkg::MC_IRQ_CTRL: begin
                        n_cnt_en = i_data_in[7];
                        n_irq_en = i_data_in[0];
                        if (!i_data_in[0]) begin
                            n_irq_pend = 1'b0;
                        end
                    end
                    cbm_pkg::MC_CNT_LO: n_counter[7:0]  = i_data_in;
                    cbm_pkg::MC_CNT_HI: n_counter[15:8] = i_data_in;
                    default: n_chr_bank[r_latch[2:0]] = i_data_in;
                endcase
            end
            if (i_command == cbm_pkg::CMD_TICK && r_cnt_en) begin
                if (r_counter == '0) begin
                    n_counter = '1;
                    if (r_irq_en) begin
                        n_irq_pend = 1'b1;
                    end
                end else begin
                    n_counter = r_counter - 1'b1;
                end
            end
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                cbm_pkg::REG_PRG_COUNT: n_prg_count = i_cfg_data;
                cbm_pkg::REG_CHR_COUNT: n_chr_count = i_cfg_data;
                cbm_pkg::REG_CHR_RAM:   n_chr_ram   = i_cfg_data[0];
                cbm_pkg::REG_MIRROR: begin
                    n_init_mirror = i_cfg_data[1:0];
                    n_mirror      = i_cfg_data[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.needs_div = dec_div;

    assign rem_mid = rem_step(r_rem, r_dvd[BB-1], r_dsr);
    assign rem_end = rem_step(rem_mid, r_dvd[BB-2], r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count   <= cbm_pkg::PRG_COUNT_RST;
            r_chr_count   <= cbm_pkg::CHR_COUNT_RST;
            r_chr_ram     <= 1'b0;
            r_init_mirror <= 2'd0;
            r_latch       <= '0;
            r_chr_bank    <= '{default: '0};
            r_prg_bank    <= '{default: '0};
            r_low_ram     <= 1'b0;
            r_mirror      <= 2'd0;
            r_cnt_en      <= 1'b0;
            r_irq_en      <= 1'b0;
            r_irq_pend    <= 1'b0;
            r_counter     <= '0;
        end else begin
            r_prg_count   <= n_prg_count;
            r_chr_count   <= n_chr_count;
            r_chr_ram     <= n_chr_ram;
            r_init_mirror <= n_init_mirror;
            r_latch       <= n_latch;
            r_chr_bank    <= n_chr_bank;
            r_prg_bank    <= n_prg_bank;
            r_low_ram     <= n_low_ram;
            r_mirror      <= n_mirror;
            r_cnt_en      <= n_cnt_en;
            r_irq_en      <= n_irq_en;
            r_irq_pend    <= n_irq_pend;
            r_counter     <= n_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= dec_target;
            r_wr     <= dec_wr;
            r_wdata  <= dec_wr ? i_data_in : 8'd0;
            r_off    <= off;
            r_rem    <= dec_bank;
            r_dvd    <= dec_dvd;
            r_dsr    <= dec_dsr;
        end else if (i_cmd.div_step) begin
            r_rem    <= rem_end;
            r_dvd    <= {r_dvd[BB-3:0], 2'b00};
        end
    end

    always_comb begin
        case (r_target)
            cbm_pkg::TGT_PRG_ROM:
                full_addr = cbm_pkg::ADDR_FULL_BITS'({r_rem, r_off});
            cbm_pkg::TGT_CHR_ROM:
                full_addr = cbm_pkg::ADDR_FULL_BITS'({r_rem[BB-1:0], r_off[9:0]});
            cbm_pkg::TGT_PRG_RAM, cbm_pkg::TGT_CHR_RAM:
                full_addr = cbm_pkg::ADDR_FULL_BITS'(r_off);
            default:
                full_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_target     <= r_target;
            o_mem_addr   <= full_addr[MEM_ADDR_BITS-1:0];
            o_mem_write  <= r_wr;
            o_write_data <= r_wdata;
            o_irq        <= r_irq_pend;
            o_mirroring  <= r_mirror;
        end
    end

endmodule

>>> rtl/cartridge_bank_mapper_irq_unit.sv
// Cartridge bank mapper with interrupt counter.
// Input channel (i_in_valid / o_in_ready) carries one bus item: cpu write,
// cpu read, ppu read, ppu write or cpu clock tick, with address and data.
// Output channel (o_out_valid / i_out_ready) returns one result per item:
// memory target, physical address, write strobe and data, interrupt level
// and mirroring after that item.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) sets the
// bank counts, character RAM mode and initial mirroring; write it only
// while no item is in flight.
// Items with no bank reduction (including reads of the fixed $E000 window)
// pass from the item registers loaded at acceptance straight into the
// output register; reads through a switchable ROM bank first have the
// bank number reduced modulo the bank count by a shared remainder unit
// taking 2 bits per cycle. One item is in flight at a time; the next is
// accepted as soon as the previous result sits in the output register.
// Reset clears all bank, command and counter state and loads the default
// configuration. When the receiver stalls the result holds in the output
// register and the block stops accepting after one more item.
module cartridge_bank_mapper_irq_unit #(
    parameter int MEM_ADDR_BITS = cbm_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_command,
    input  logic [15:0]              i_address,
    input  logic [7:0]               i_data_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [2:0]               o_target,
    output logic [MEM_ADDR_BITS-1:0] o_mem_addr,
    output logic                     o_mem_write,
    output logic [7:0]               o_write_data,
    output logic                     o_irq,
    output logic [1:0]               o_mirroring,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [8:0]               i_cfg_data
);

    cbm_pkg::t_ctrl_cmd  cmd;
    cbm_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    cbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cbm_datapath #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_command    (i_command),
        .i_address    (i_address),
        .i_data_in    (i_data_in),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_target     (o_target),
        .o_mem_addr   (o_mem_addr),
        .o_mem_write  (o_mem_write),
        .o_write_data (o_write_data),
        .o_irq        (o_irq),
        .o_mirroring  (o_mirroring)
    );

endmodule

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAB = cbm_pkg::MEM_ADDR_BITS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 135;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam logic [1:0] MIR_HORIZONTAL = 2'd0;
    localparam logic [1:0] MIR_VERTICAL   = 2'd1;
    localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;
    localparam logic [1:0] MIR_SINGLE_HI  = 2'd3;

    typedef struct packed {
        logic [2:0]     target;
        logic [MAB-1:0] mem_addr;
        logic           mem_write;
        logic [7:0]     write_data;
        logic           irq;
        logic [1:0]     mirroring;
    } t_bus_result;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic [2:0]     command = '0;
    logic [15:0]    address = '0;
    logic [7:0]     data_in = '0;
    logic           out_ready = 1'b0;
    logic           cfg_valid = 1'b0;
    logic [1:0]     cfg_index = '0;
    logic [8:0]     cfg_data = '0;

    logic           o_in_ready;
    logic           o_out_valid;
    logic [2:0]     o_target;
    logic [MAB-1:0] o_mem_addr;
    logic           o_mem_write;
    logic [7:0]     o_write_data;
    logic           o_irq;
    logic [1:0]     o_mirroring;
    logic           o_cfg_ready;

    // mapper state as predicted
    int unsigned prg_count = 32'(cbm_pkg::PRG_COUNT_RST);
    int unsigned chr_count = 32'(cbm_pkg::CHR_COUNT_RST);
    logic        chr_ram = 1'b0;
    logic [3:0]  cmd_latch = '0;
    logic [7:0]  chr_bank_r [8] = '{default: '0};
    logic [5:0]  prg_bank_r [4] = '{default: '0};
    logic        low_is_ram = 1'b0;
    logic [1:0]  mirror_mode = MIR_HORIZONTAL;
    logic        count_en = 1'b0;
    logic        irq_en = 1'b0;
    logic        irq_pend = 1'b0;
    logic [15:0] irq_count = '0;

    t_bus_result pending_results[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    bit          source_calm = 1'b0;
    bit          sink_calm = 1'b0;
    int unsigned sink_hold = 0;

    cartridge_bank_mapper_irq_unit #(
        .MEM_ADDR_BITS(MAB)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (command),
        .i_address    (address),
        .i_data_in    (data_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_target     (o_target),
        .o_mem_addr   (o_mem_addr),
        .o_mem_write  (o_mem_write),
        .o_write_data (o_write_data),
        .o_irq        (o_irq),
        .o_mirroring  (o_mirroring),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic run_mapper_command(input logic [7:0] d);
        case (cmd_latch)
            cbm_pkg::MC_PRG_LOW: begin
                low_is_ram = d[6];
                prg_bank_r[3] = d[5:0];
            end
            cbm_pkg::MC_PRG_0, cbm_pkg::MC_PRG_1, cbm_pkg::MC_PRG_2: begin
                prg_bank_r[2'(cmd_latch - cbm_pkg::MC_PRG_0)] = d[5:0];
            end
            cbm_pkg::MC_MIRROR: begin
                case (d[1:0])
                    2'd0: mirror_mode = MIR_VERTICAL;
                    2'd1: mirror_mode = MIR_HORIZONTAL;
                    default: mirror_mode = d[1:0];
                endcase
            end
            cbm_pkg::MC_IRQ_CTRL: begin
                count_en = d[7];
                irq_en = d[0];
                if (!d[0]) irq_pend = 1'b0;
            end
            cbm_pkg::MC_CNT_LO: irq_count[7:0] = d;
            cbm_pkg::MC_CNT_HI: irq_count[15:8] = d;
            default: chr_bank_r[cmd_latch[2:0]] = d;
        endcase
    endtask

    task automatic map_bus_item(input logic [2:0] cmd, input logic [15:0] addr,
                                input logic [7:0] data, output t_bus_result res);
        int unsigned bank;
        int unsigned phys;
        logic [12:0] off;
        off = addr[12:0];
        res = '0;
        phys = 0;
        case (cmd)
            cbm_pkg::CMD_CPU_WRITE: begin
                if (addr >= 16'h8000) begin
                    if (addr <= 16'h9FFF) cmd_latch = data[3:0];
                    else if (addr <= 16'hBFFF) run_mapper_command(data);
                end else if (addr >= 16'h6000 && low_is_ram) begin
                    res.target = cbm_pkg::TGT_PRG_RAM;
                    res.mem_write = 1'b1;
                    phys = 32'(off);
                end
            end
            cbm_pkg::CMD_CPU_READ: begin
                if (addr >= 16'h6000 && addr < 16'h8000 && low_is_ram) begin
                    res.target = cbm_pkg::TGT_PRG_RAM;
                    phys = 32'(off);
                end else if (addr >= 16'h6000 && prg_count != 0) begin
                    if (addr < 16'h8000) bank = prg_bank_r[3] % prg_count;
                    else if (addr >= 16'hE000) bank = prg_count - 1;
                    else bank = prg_bank_r[addr[14:13]] % prg_count;
                    res.target = cbm_pkg::TGT_PRG_ROM;
                    phys = bank * 8192 + off;
                end
            end
            cbm_pkg::CMD_PPU_READ, cbm_pkg::CMD_PPU_WRITE: begin
                if (chr_ram) begin
                    res.target = cbm_pkg::TGT_CHR_RAM;
                    res.mem_write = (cmd == cbm_pkg::CMD_PPU_WRITE);
                    phys = 32'(off);
                end else if (cmd == cbm_pkg::CMD_PPU_READ && chr_count != 0) begin
                    bank = chr_bank_r[off[12:10]] % chr_count;
                    res.target = cbm_pkg::TGT_CHR_ROM;
                    phys = bank * 1024 + off[9:0];
                end
            end
            cbm_pkg::CMD_TICK: begin
                if (count_en) begin
                    if (irq_count == 16'h0000) begin
                        if (irq_en) irq_pend = 1'b1;
                        irq_count = 16'hFFFF;
                    end else begin
                        irq_count = irq_count - 16'd1;
                    end
                end
            end
            default: ;
        endcase
        res.mem_addr = phys[MAB-1:0];
        res.write_data = res.mem_write ? data : 8'h00;
        res.irq = irq_pend;
        res.mirroring = mirror_mode;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic int unsigned pick_bank_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 10) return $urandom_range(257, 511);
        if (r < 20) return 1;
        if (r < 30) return 256;
        return $urandom_range(1, 256);
    endfunction

    task automatic send_bus_item(input logic [2:0] cmd, input logic [15:0] addr,
                                 input logic [7:0] data);
        int unsigned gap;
        t_bus_result want;
        cfg_valid <= 1'b0;
        if ($urandom_range(0, 59) == 0) source_calm = !source_calm;
        gap = source_calm ? 0 : pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        address <= addr;
        data_in <= data;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        map_bus_item(cmd, addr, data, want);
        pending_results.push_back(want);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_mapper_reg(input logic [1:0] idx, input logic [8:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        case (idx)
            cbm_pkg::REG_PRG_COUNT: prg_count = 32'(value);
            cbm_pkg::REG_CHR_COUNT: chr_count = 32'(value);
            cbm_pkg::REG_CHR_RAM:   chr_ram = value[0];
            cbm_pkg::REG_MIRROR:    mirror_mode = value[1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input t_bus_result want,
                                   input t_bus_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected tgt %0d addr %h wr %b data %h irq %b mir %0d",
                     what, want.target, want.mem_addr, want.mem_write,
                     want.write_data, want.irq, want.mirroring);
            $display("    actual tgt %0d addr %h wr %b data %h irq %b mir %0d",
                     got.target, got.mem_addr, got.mem_write, got.write_data,
                     got.irq, got.mirroring);
        end
    endtask

    always @(posedge clk) begin
        t_bus_result got;
        t_bus_result want;
        if (rst_n && o_out_valid && out_ready) begin
            got = {o_target, o_mem_addr, o_mem_write, o_write_data, o_irq, o_mirroring};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) report_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk) begin
        int unsigned r;
        if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
            out_ready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r == 0) sink_calm = !sink_calm;
            if (sink_calm || r < 70) begin
                out_ready <= 1'b1;
            end else begin
                sink_hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                out_ready <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_reset_defaults();
        send_bus_item(cbm_pkg::CMD_CPU_READ, 16'h8000, 8'h00);
        send_bus_item(cbm_pkg::CMD_CPU_READ, 16'hFFFF, 8'hFF);
        send_bus_item(cbm_pkg::CMD_CPU_READ, 16'h5FFF, 8'h00);
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'h6000, 8'hA5);
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'h0000, 8'hFF);
        send_bus_item(cbm_pkg::CMD_PPU_WRITE, 16'h0400, 8'h5A);
        send_bus_item(CMD_UNUSED, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_mapper_commands();
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'h8000, {4'h0, cbm_pkg::MC_PRG_LOW});
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'hBFFF, 8'h7F);
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'h7FFF, 8'hFF);
        send_bus_item(cbm_pkg::CMD_CPU_READ, 16'h6000, 8'h00);
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'h9FFF, {4'hF, cbm_pkg::MC_PRG_0});
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'hA000, 8'hFF);
        send_bus_item(cbm_pkg::CMD_CPU_READ, 16'h8000, 8'h00);
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'h8123, {4'h0, cbm_pkg::MC_MIRROR});
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'hA456, 8'hFC);
    endtask

    task automatic test_irq_counter();
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'h8000, {4'h0, cbm_pkg::MC_CNT_LO});
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'hA000, 8'h01);
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'h8000, {4'h0, cbm_pkg::MC_IRQ_CTRL});
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'hA000, 8'h81);
        send_bus_item(cbm_pkg::CMD_TICK, 16'h0000, 8'h00);
        send_bus_item(cbm_pkg::CMD_TICK, 16'hFFFF, 8'hFF);
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'h8000, {4'h0, cbm_pkg::MC_IRQ_CTRL});
        send_bus_item(cbm_pkg::CMD_CPU_WRITE, 16'hA000, 8'h80);
    endtask

    task automatic test_count_limits();
        write_mapper_reg(cbm_pkg::REG_PRG_COUNT, 9'd0);
        send_bus_item(cbm_pkg::CMD_CPU_READ, 16'hE000, 8'h00);
        write_mapper_reg(cbm_pkg::REG_CHR_COUNT, 9'd0);
        send_bus_item(cbm_pkg::CMD_PPU_READ, 16'h0000, 8'h00);
        write_mapper_reg(cbm_pkg::REG_CHR_RAM, 9'd1);
        send_bus_item(cbm_pkg::CMD_PPU_WRITE, 16'hFFFF, 8'h3C);
        write_mapper_reg(cbm_pkg::REG_MIRROR, {7'd0, MIR_SINGLE_HI});
        send_bus_item(cbm_pkg::CMD_TICK, 16'h1234, 8'h00);
        write_mapper_reg(cbm_pkg::REG_PRG_COUNT, 9'd511);
        send_bus_item(cbm_pkg::CMD_CPU_READ, 16'hFFFF, 8'h00);
    endtask

    task automatic send_random_burst(inout int unsigned sent);
        int unsigned r;
        int unsigned n;
        logic [3:0] code;
        logic [7:0] d;
        logic [2:0] win;
        logic [2:0] cmd;
        logic [15:0] addr;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            code = 4'($urandom_range(0, 15));
            send_bus_item(cbm_pkg::CMD_CPU_WRITE, {cbm_pkg::WIN_LATCH, 13'($urandom)},
                          {4'($urandom), code});
            d = 8'($urandom);
            case (code)
                cbm_pkg::MC_IRQ_CTRL: d[7] = ($urandom_range(0, 3) != 0);
                cbm_pkg::MC_CNT_LO: if ($urandom_range(0, 1) == 1) d = 8'($urandom_range(0, 6));
                cbm_pkg::MC_CNT_HI: if ($urandom_range(0, 3) != 0) d = 8'h00;
                default: ;
            endcase
            send_bus_item(cbm_pkg::CMD_CPU_WRITE, {cbm_pkg::WIN_EXEC, 13'($urandom)}, d);
            sent += 2;
        end else if (r < 50) begin
            if ($urandom_range(0, 4) == 0) win = 3'($urandom_range(0, 2));
            else win = 3'($urandom_range(3, 7));
            send_bus_item(cbm_pkg::CMD_CPU_READ, {win, 13'($urandom)}, 8'($urandom));
            sent += 1;
        end else if (r < 58) begin
            if ($urandom_range(0, 3) != 0) addr = {cbm_pkg::WIN_LOW, 13'($urandom)};
            else addr = 16'($urandom);
            send_bus_item(cbm_pkg::CMD_CPU_WRITE, addr, 8'($urandom));
            sent += 1;
        end else if (r < 73) begin
            cmd = ($urandom_range(0, 1) == 1) ? cbm_pkg::CMD_PPU_READ : cbm_pkg::CMD_PPU_WRITE;
            if ($urandom_range(0, 3) == 0) addr = 16'($urandom);
            else addr = {3'b000, 13'($urandom)};
            send_bus_item(cmd, addr, 8'($urandom));
            sent += 1;
        end else if (r < 90) begin
            n = $urandom_range(1, 8);
            repeat (n) send_bus_item(cbm_pkg::CMD_TICK, 16'($urandom), 8'($urandom));
            sent += n;
        end else begin
            send_bus_item(3'($urandom), 16'($urandom), 8'($urandom));
            sent += 1;
        end
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_mapper_reg(cbm_pkg::REG_PRG_COUNT, 9'd1);
                    write_mapper_reg(cbm_pkg::REG_CHR_COUNT, 9'd1);
                    write_mapper_reg(cbm_pkg::REG_CHR_RAM, 9'd0);
                    write_mapper_reg(cbm_pkg::REG_MIRROR, {7'd0, MIR_VERTICAL});
                end
                1: begin
                    write_mapper_reg(cbm_pkg::REG_PRG_COUNT, 9'd256);
                    write_mapper_reg(cbm_pkg::REG_CHR_COUNT, 9'd256);
                    write_mapper_reg(cbm_pkg::REG_CHR_RAM, 9'd0);
                    write_mapper_reg(cbm_pkg::REG_MIRROR, {7'd0, MIR_SINGLE_LO});
                end
                2: begin
                    write_mapper_reg(cbm_pkg::REG_PRG_COUNT, 9'd0);
                    write_mapper_reg(cbm_pkg::REG_CHR_COUNT, 9'd0);
                    write_mapper_reg(cbm_pkg::REG_CHR_RAM, 9'd0);
                    write_mapper_reg(cbm_pkg::REG_MIRROR, {7'd0, MIR_SINGLE_HI});
                end
                3: begin
                    write_mapper_reg(cbm_pkg::REG_PRG_COUNT, 9'(pick_bank_count()));
                    write_mapper_reg(cbm_pkg::REG_CHR_COUNT, 9'(pick_bank_count()));
                    write_mapper_reg(cbm_pkg::REG_CHR_RAM, 9'd1);
                    write_mapper_reg(cbm_pkg::REG_MIRROR, {7'd0, MIR_HORIZONTAL});
                end
                default: begin
                    write_mapper_reg(cbm_pkg::REG_PRG_COUNT, 9'(pick_bank_count()));
                    write_mapper_reg(cbm_pkg::REG_CHR_COUNT, 9'(pick_bank_count()));
                    write_mapper_reg(cbm_pkg::REG_CHR_RAM, 9'($urandom_range(0, 2) == 0));
                    write_mapper_reg(cbm_pkg::REG_MIRROR, 9'($urandom_range(0, 3)));
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) send_random_burst(sent);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_mapper_commands();
        test_irq_counter();
        test_count_limits();
        test_random_traffic();
        wait_for_results();
        cfg_valid <= 1'b0;
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
